// ----- rtl/core/block_range_set_iterator_top_defines.svh -----
// ----------------------------------------------------------------------------
// block range set iterator assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BLOCK_RANGE_SET_ITERATOR_TOP_DEFINES_SVH
`define BLOCK_RANGE_SET_ITERATOR_TOP_DEFINES_SVH

// same-cycle implication under asynchronous reset
`define BRSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed in %m");

// next-cycle implication under asynchronous reset
`define BRSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed in %m");

`endif

// ----- rtl/core/brsi_pkg.sv -----
// ----------------------------------------------------------------------------
// brsi_pkg
// types and constants shared by the range set iterator cells and top level
// ----------------------------------------------------------------------------
package brsi_pkg;

	localparam int BLK_W = 32;
	localparam int ST_W  = 3;

	localparam logic [BLK_W-1:0] RST_LO = 32'h0000_0001;
	localparam logic [BLK_W-1:0] RST_HI = 32'hFFFF_FFFF;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [ST_W-1:0] ST_MISS_ERR = 3'd2;
	localparam logic [ST_W-1:0] ST_MISS_OK  = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

	localparam logic OP_NEXT    = 1'b0;
	localparam logic OP_EXCLUDE = 1'b1;

	// what a cell shows its neighbors
	typedef struct packed {
		logic [BLK_W-1:0] lo;
		logic [BLK_W-1:0] hi;
		logic             valid;
		logic             ge;    // range lies at or above the target block
		logic             hit;   // range holds the target block
	} brsi_view_t;

	// running result of the lookup sweep
	typedef struct packed {
		logic hit;
		logic split;
		logic del;
	} brsi_scan_t;

	// broadcast update command
	typedef struct packed {
		logic             commit;
		logic             split;
		logic             del;
		logic [BLK_W-1:0] blk;
	} brsi_cmd_t;

endpackage

// ----- rtl/core/block_range_set_iterator_top.sv -----
// ----------------------------------------------------------------------------
// block_range_set_iterator_top
// ordered list of free block ranges kept in a row of cells
//
//   channel  | dir | tdata                           | tuser
//   s_*      | in  | [31:0] block, [32] miss_ok      | [0] operation
//   m_*      | out | [31:0] block_out                | [2:0] status
//
// after the input transfer the lookup sweep ripples down the cell row in S_SCAN,
// then the result commits in S_DONE; m_tvalid rises and s_tready returns
// together, on the commit
// s_tready is high only between items; a stalled result holds in m_* and the
// next item may be taken meanwhile, committing once the result register frees
// reset restores the single range 1 to 0xffffffff at once, no clearing pass
// ----------------------------------------------------------------------------
module block_range_set_iterator_top #(
	parameter int MAX_RANGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] block, [32] miss_ok, [39:33] zero
	input  logic [0:0]  s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] block_out
	output logic [2:0]  m_tuser    // [2:0] status
);

	localparam int CNT_W = $clog2(MAX_RANGES);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                 state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       op_q;
	logic                       miss_ok_q;
	logic                       empty_q;
	logic [brsi_pkg::BLK_W-1:0] blk_q;
	logic                       m_tvalid_q;
	logic [brsi_pkg::BLK_W-1:0] m_tdata_q;
	logic [brsi_pkg::ST_W-1:0]  m_tuser_q;

	brsi_pkg::brsi_view_t view   [MAX_RANGES];
	brsi_pkg::brsi_scan_t scan   [MAX_RANGES];
	brsi_pkg::brsi_cmd_t  cmd;
	brsi_pkg::brsi_scan_t tail;
	logic [brsi_pkg::ST_W-1:0] status;
	logic                       fire;
	logic                       s_xfer;

	assign s_tready = (state_q == S_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign tail     = scan[MAX_RANGES-1];
	assign fire     = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		if (empty_q) begin
			status = brsi_pkg::ST_EMPTY;
		end else if (!tail.hit) begin
			status = miss_ok_q ? brsi_pkg::ST_MISS_OK : brsi_pkg::ST_MISS_ERR;
		end else if (tail.split && view[MAX_RANGES-1].valid) begin
			status = brsi_pkg::ST_FULL;
		end else begin
			status = brsi_pkg::ST_OK;
		end
	end

	assign cmd.commit = fire && (status == brsi_pkg::ST_OK);
	assign cmd.split  = tail.split;
	assign cmd.del    = tail.del;
	assign cmd.blk    = blk_q;

	for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
		brsi_pkg::brsi_view_t left_v;
		brsi_pkg::brsi_view_t right_v;
		brsi_pkg::brsi_scan_t scan_in;

		if (k == 0) begin : g_first
			assign left_v  = '0;
			assign scan_in = '0;
		end else begin : g_mid
			assign left_v  = view[k-1];
			assign scan_in = scan[k-1];
		end

		if (k == MAX_RANGES - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_inner
			assign right_v = view[k+1];
		end

		brsi_cell #(
			.HEAD (k == 0)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.left     (left_v),
			.right    (right_v),
			.scan_in  (scan_in),
			.view     (view[k]),
			.scan_out (scan[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_xfer) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
					end
				end
				S_SCAN: begin
					// S_SCAN waits for the sweep to register through every cell down to the tail
					if (cnt_q == CNT_W'(MAX_RANGES - 1)) begin
						state_q <= S_DONE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_DONE: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// next targets the lowest block of the head range
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			op_q      <= s_tuser[0];
			miss_ok_q <= s_tdata[32];
			empty_q   <= (s_tuser[0] == brsi_pkg::OP_NEXT) && !view[0].valid;
			blk_q     <= (s_tuser[0] == brsi_pkg::OP_EXCLUDE) ? s_tdata[31:0] : view[0].lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tuser_q <= status;
			m_tdata_q <= ((op_q == brsi_pkg::OP_NEXT) && (status == brsi_pkg::ST_OK))
				? blk_q : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ----- rtl/core/brsi_cell.sv -----
// ----------------------------------------------------------------------------
// brsi_cell
// one range slot: compares against the target, passes the lookup sweep on,
// and trims, splits into or shifts from its neighbors on commit
// ----------------------------------------------------------------------------
module brsi_cell #(
	parameter bit HEAD = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  brsi_pkg::brsi_cmd_t  cmd,
	input  brsi_pkg::brsi_view_t left,
	input  brsi_pkg::brsi_view_t right,
	input  brsi_pkg::brsi_scan_t scan_in,
	output brsi_pkg::brsi_view_t view,
	output brsi_pkg::brsi_scan_t scan_out
);

	logic [brsi_pkg::BLK_W-1:0] lo_q;
	logic [brsi_pkg::BLK_W-1:0] hi_q;
	logic                       valid_q;
	brsi_pkg::brsi_scan_t       scan_q;
	logic                       ge;
	logic                       hit;
	logic                       split;
	logic                       del;

	assign ge    = valid_q && (hi_q >= cmd.blk);
	assign hit   = ge && (lo_q <= cmd.blk);
	assign split = hit && (lo_q < cmd.blk) && (cmd.blk < hi_q);
	assign del   = hit && (lo_q == hi_q);

	assign view.lo    = lo_q;
	assign view.hi    = hi_q;
	assign view.valid = valid_q;
	assign view.ge    = ge;
	assign view.hit   = hit;

	assign scan_out = scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q.hit   <= scan_in.hit | hit;
			scan_q.split <= scan_in.split | split;
			scan_q.del   <= scan_in.del | del;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q    <= brsi_pkg::RST_LO;
			hi_q    <= brsi_pkg::RST_HI;
			valid_q <= HEAD;
		end else if (cmd.commit) begin
			if (cmd.del) begin
				// entries from the deleted one upward pull from the right
				if (ge) begin
					lo_q    <= right.lo;
					hi_q    <= right.hi;
					valid_q <= right.valid;
				end
			end else if (cmd.split) begin
				if (left.ge) begin
					valid_q <= left.valid;
					if (left.hit) begin
						lo_q <= cmd.blk + 1'b1;
						hi_q <= left.hi;
					end else begin
						lo_q <= left.lo;
						hi_q <= left.hi;
					end
				end else if (hit) begin
					hi_q <= cmd.blk - 1'b1;
				end
			end else if (hit) begin
				if (lo_q == cmd.blk) begin
					lo_q <= lo_q + 1'b1;
				end else begin
					hi_q <= hi_q - 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/core/brsi_checker.sv -----
// ----------------------------------------------------------------------------
// brsi_checker
// port-level checks on the range set iterator, bound to the top level
// ----------------------------------------------------------------------------
`include "block_range_set_iterator_top_defines.svh"

module brsi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// a held result keeps its contents
	`BRSI_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// status code stays within the defined set
	`BRSI_ASSERT_NOW(a_status_range, clk, arst_n, m_tvalid, m_tuser <= brsi_pkg::ST_FULL)

	// only a successful result carries a block number
	`BRSI_ASSERT_NOW(a_zero_block, clk, arst_n, m_tvalid && (m_tuser != brsi_pkg::ST_OK), m_tdata == 32'd0)

	// input closes right after a transfer
	`BRSI_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// an empty set report carries no block
	`BRSI_ASSERT_NOW(a_empty_next, clk, arst_n, m_tvalid && (m_tuser == brsi_pkg::ST_EMPTY), m_tdata == 32'd0)

endmodule

bind block_range_set_iterator_top brsi_checker u_brsi_checker (.*);
